// File: src/pmf_pkg.sv
package pmf_pkg;

	// scan capacity of one buffer, in bytes
	localparam int unsigned BufferBytes = 65536;
	localparam int unsigned OffsetWidth = 17;
	localparam int unsigned LengthWidth = 32;

	// message length fields required by the fixed-size ids
	localparam logic [LengthWidth-1:0] LenSimple  = 32'h1;
	localparam logic [LengthWidth-1:0] LenHave    = 32'h5;
	localparam logic [LengthWidth-1:0] LenRequest = 32'hd;
	localparam logic [LengthWidth-1:0] LenPort    = 32'h3;

	// message ids
	localparam logic [7:0] IdInterested = 8'd3;
	localparam logic [7:0] IdHave       = 8'd4;
	localparam logic [7:0] IdBitfield   = 8'd5;
	localparam logic [7:0] IdRequest    = 8'd6;
	localparam logic [7:0] IdPiece      = 8'd7;
	localparam logic [7:0] IdCancel     = 8'd8;
	localparam logic [7:0] IdPort       = 8'd9;

	typedef enum logic [1:0] {
		PH_LEN = 2'd0,
		PH_ID  = 2'd1,
		PH_PAY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_COMPLETE = 2'd0,
		ST_PARTIAL  = 2'd1,
		ST_UNKNOWN  = 2'd2
	} status_t;

	typedef struct packed {
		logic [OffsetWidth-1:0] complete_bytes;
		status_t                status;
	} result_t;

	// true when an id byte may carry the given message length
	function automatic logic id_accepts(input logic [7:0] id, input logic [LengthWidth-1:0] len);
		logic ok;
		ok = 1'b0;
		if (id <= IdInterested) begin
			ok = (len == LenSimple);
		end else if (id == IdHave) begin
			ok = (len == LenHave);
		end else if (id == IdRequest || id == IdCancel) begin
			ok = (len == LenRequest);
		end else if (id == IdPort) begin
			ok = (len == LenPort);
		end else if (id == IdBitfield || id == IdPiece) begin
			ok = (len != '0);
		end
		return ok;
	endfunction

endpackage

// File: src/pmf_scanner.sv
module pmf_scanner (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              end_of_buffer,
	output pmf_pkg::result_t  result
);

	localparam logic [pmf_pkg::OffsetWidth-1:0] Limit =
		pmf_pkg::OffsetWidth'(pmf_pkg::BufferBytes);

	pmf_pkg::phase_t                    phase_q, phase_n;
	logic [1:0]                         hdr_cnt_q, hdr_cnt_n;
	logic [pmf_pkg::LengthWidth-1:0]    msg_len_q, msg_len_n;
	logic [pmf_pkg::LengthWidth-1:0]    remain_q, remain_n;
	logic [pmf_pkg::OffsetWidth-1:0]    start_q, start_n;
	logic [pmf_pkg::OffsetWidth-1:0]    offset_q, offset_n;
	logic                               stopped_q, stopped_n;
	logic [pmf_pkg::LengthWidth-1:0]    len_shift;
	logic [pmf_pkg::LengthWidth-1:0]    len_minus;
	logic [pmf_pkg::LengthWidth-1:0]    rem_minus;

	assign len_shift = {msg_len_q[pmf_pkg::LengthWidth-9:0], data_byte};
	assign len_minus = msg_len_q - pmf_pkg::LengthWidth'(1);
	assign rem_minus = remain_q - pmf_pkg::LengthWidth'(1);

	// next scan state for the incoming word
	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		msg_len_n = msg_len_q;
		remain_n  = remain_q;
		start_n   = start_q;
		offset_n  = offset_q;
		stopped_n = stopped_q;
		if (!stopped_q && offset_q < Limit) begin
			offset_n = offset_q + pmf_pkg::OffsetWidth'(1);
			case (phase_q)
				pmf_pkg::PH_LEN: begin
					msg_len_n = len_shift;
					if (hdr_cnt_q == 2'd3) begin
						hdr_cnt_n = 2'd0;
						if (len_shift == '0) begin
							start_n = offset_n;
						end else begin
							phase_n = pmf_pkg::PH_ID;
						end
					end else begin
						hdr_cnt_n = hdr_cnt_q + 2'd1;
					end
				end
				pmf_pkg::PH_ID: begin
					if (!pmf_pkg::id_accepts(data_byte, msg_len_q)) begin
						stopped_n = 1'b1;
					end else if (len_minus == '0) begin
						start_n   = offset_n;
						phase_n   = pmf_pkg::PH_LEN;
						msg_len_n = '0;
						remain_n  = '0;
					end else begin
						remain_n = len_minus;
						phase_n  = pmf_pkg::PH_PAY;
					end
				end
				pmf_pkg::PH_PAY: begin
					remain_n = rem_minus;
					if (rem_minus == '0) begin
						start_n   = offset_n;
						phase_n   = pmf_pkg::PH_LEN;
						msg_len_n = '0;
					end
				end
				default: begin
					phase_n = pmf_pkg::PH_LEN;
				end
			endcase
		end
	end

	// report for the last word of a buffer
	always_comb begin
		result.complete_bytes = start_n;
		if (stopped_n) begin
			result.status = pmf_pkg::ST_UNKNOWN;
		end else if (phase_n != pmf_pkg::PH_LEN || hdr_cnt_n != 2'd0) begin
			result.status = pmf_pkg::ST_PARTIAL;
		end else begin
			result.status = pmf_pkg::ST_COMPLETE;
		end
	end

	// scan state, cleared again after each buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pmf_pkg::PH_LEN;
			hdr_cnt_q <= '0;
			msg_len_q <= '0;
			remain_q  <= '0;
			start_q   <= '0;
			offset_q  <= '0;
			stopped_q <= 1'b0;
		end else if (take) begin
			if (end_of_buffer) begin
				phase_q   <= pmf_pkg::PH_LEN;
				hdr_cnt_q <= '0;
				msg_len_q <= '0;
				remain_q  <= '0;
				start_q   <= '0;
				offset_q  <= '0;
				stopped_q <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				hdr_cnt_q <= hdr_cnt_n;
				msg_len_q <= msg_len_n;
				remain_q  <= remain_n;
				start_q   <= start_n;
				offset_q  <= offset_n;
				stopped_q <= stopped_n;
			end
		end
	end

endmodule

// File: src/peer_message_framer.sv
// Peer message framer.
// Input channel (byte_valid / byte_stall): one buffer word per cycle unless
// stalled, data_byte with end_of_buffer high on the last word. Words are split
// into length-prefixed peer messages (4-byte big-endian length, id, payload).
// Output channel (result_valid / result_stall): one result per buffer, given
// for its last word: complete_bytes covered by complete valid messages and a
// status (0 all complete, 1 partial message at the end, 2 unknown message).
// A result is registered: the last word lands in the input register, and the
// result register is loaded from the scan logic when the scanner takes that
// word. Throughput: one word per cycle while byte_stall is low; the next scan
// state is computed combinationally from each word. While a result waits
// under result_stall, words keep flowing until a second last word reaches the
// scanner; then byte_stall rises until the result is taken. Reset clears the
// scan state and both valid flags; after each last word the scanner returns
// to its reset state for the next buffer.
module peer_message_framer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            end_of_buffer,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [pmf_pkg::OffsetWidth-1:0] complete_bytes,
	output logic [1:0]                      status
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              eob_s1;
	logic              take;
	logic              res_valid_q;
	pmf_pkg::result_t  res_c;
	pmf_pkg::result_t  res_q;

	// scanner moves unless a last word meets a result still waiting
	assign take       = valid_s1 && (!eob_s1 || !res_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !take;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			data_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	pmf_scanner u_scanner (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.data_byte     (data_s1),
		.end_of_buffer (eob_s1),
		.result        (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && eob_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && eob_s1) begin
			res_q <= res_c;
		end
	end

	assign result_valid   = res_valid_q;
	assign complete_bytes = res_q.complete_bytes;
	assign status         = res_q.status;

endmodule

// File: tb/peer_message_framer_tb.sv
`timescale 1ns / 1ps

module peer_message_framer_tb;
	import pmf_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int DrainCycles   = 8;
	localparam int PhaseBytes    = 315;

	// expected framing of each buffer, kept as a shadow of the scan state
	class framer_scoreboard;
		phase_t                 scan_phase;
		logic [1:0]             hdr_count;
		logic [LengthWidth-1:0] msg_len;
		logic [LengthWidth-1:0] remaining;
		logic [OffsetWidth-1:0] good_end;
		logic [OffsetWidth-1:0] buf_off;
		bit                     stopped;
		result_t                expected_q[$];
		int                     failures;

		function new();
			failures = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			scan_phase = PH_LEN;
			hdr_count  = '0;
			msg_len    = '0;
			remaining  = '0;
			good_end   = '0;
			buf_off    = '0;
			stopped    = 1'b0;
		endfunction

		function void close_message();
			good_end   = buf_off;
			scan_phase = PH_LEN;
			hdr_count  = '0;
			msg_len    = '0;
			remaining  = '0;
		endfunction

		function bit id_fits(logic [7:0] id, logic [LengthWidth-1:0] len);
			bit fits;
			fits = 1'b0;
			if (id <= IdInterested) begin
				fits = (len == LenSimple);
			end
			case (id)
				IdHave: fits = (len == LenHave);
				IdRequest, IdCancel: fits = (len == LenRequest);
				IdPort: fits = (len == LenPort);
				IdBitfield, IdPiece: fits = (len != '0);
				default: ;
			endcase
			return fits;
		endfunction

		// advance the shadow scan by one accepted word
		function void note_byte(logic [7:0] b, logic last);
			result_t r;
			if (!stopped && buf_off < BufferBytes) begin
				buf_off++;
				case (scan_phase)
					PH_LEN: begin
						msg_len = {msg_len[LengthWidth-9:0], b};
						if (hdr_count == 2'd3) begin
							hdr_count = '0;
							if (msg_len == '0) close_message();
							else scan_phase = PH_ID;
						end else begin
							hdr_count++;
						end
					end
					PH_ID: begin
						if (!id_fits(b, msg_len)) begin
							stopped = 1'b1;
						end else begin
							remaining = msg_len - 1;
							if (remaining == '0) close_message();
							else scan_phase = PH_PAY;
						end
					end
					default: begin
						remaining--;
						if (remaining == '0) close_message();
					end
				endcase
			end
			// last word of the buffer yields one result
			if (last) begin
				r.complete_bytes = good_end;
				if (stopped) r.status = ST_UNKNOWN;
				else if (scan_phase != PH_LEN || hdr_count != '0) r.status = ST_PARTIAL;
				else r.status = ST_COMPLETE;
				expected_q.push_back(r);
				clear_scan();
			end
		endfunction

		function void check_result(logic [OffsetWidth-1:0] cb, logic [1:0] st);
			result_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, complete_bytes %0d status %0d",
					$time, cb, st);
				failures++;
			end else begin
				r = expected_q.pop_front();
				if (cb !== r.complete_bytes) begin
					$display("%0t: complete_bytes mismatch, expected %0d, actual %0d",
						$time, r.complete_bytes, cb);
					failures++;
				end
				if (st !== r.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, r.status, st);
					failures++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_stall;
	logic [7:0]             data_byte;
	logic                   end_of_buffer;
	logic                   result_valid;
	logic                   result_stall;
	logic [OffsetWidth-1:0] complete_bytes;
	logic [1:0]             status;

	framer_scoreboard sb;
	logic [7:0]       frame_q[$];
	int               idle_pct;
	int               stall_pct;
	int               sent_bytes;
	int               sender_idle[4] = '{0, 78, 0, 12};
	int               receiver_stall[4] = '{0, 0, 78, 12};

	peer_message_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.complete_bytes(complete_bytes),
		.status        (status)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// drive one word, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid    <= 1'b1;
		data_byte     <= b;
		end_of_buffer <= last;
		do @(posedge clk); while (byte_stall !== 1'b0);
		sb.note_byte(b, last);
		sent_bytes++;
	endtask

	// send the staged buffer, flagging its last word
	task automatic send_buffer();
		foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
		frame_q.delete();
	endtask

	// stage a length prefix, then the id and body words when the length is nonzero
	task automatic push_message(input logic [7:0] id, input logic [LengthWidth-1:0] len,
		input int body);
		frame_q.push_back(len[31:24]);
		frame_q.push_back(len[23:16]);
		frame_q.push_back(len[15:8]);
		frame_q.push_back(len[7:0]);
		if (len != '0) begin
			frame_q.push_back(id);
			repeat (body) frame_q.push_back(8'($urandom_range(255)));
		end
	endtask

	// mostly well-formed messages with random content, some broken ones
	task automatic random_buffer();
		int                     kind;
		int                     max_cut;
		logic [LengthWidth-1:0] len;
		repeat ($urandom_range(4, 1)) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				push_message('0, '0, 0);
			end else if (kind < 30) begin
				push_message(8'($urandom_range(IdInterested, 0)), LenSimple, 0);
			end else if (kind < 40) begin
				push_message(IdHave, LenHave, LenHave - 1);
			end else if (kind < 52) begin
				push_message($urandom_range(1) ? IdRequest : IdCancel, LenRequest,
					LenRequest - 1);
			end else if (kind < 60) begin
				push_message(IdPort, LenPort, LenPort - 1);
			end else if (kind < 82) begin
				len = $urandom_range(12, 1);
				push_message($urandom_range(1) ? IdBitfield : IdPiece, len, len - 1);
			end else if (kind < 88) begin
				// known id, length usually wrong
				len = $urandom_range(15);
				push_message(8'($urandom_range(IdPort, 0)), len, $urandom_range(4));
			end else if (kind < 93) begin
				len = $urandom_range(8, 1);
				push_message(8'($urandom_range(255, IdPort + 1)), len, len - 1);
			end else if (kind < 96) begin
				// length far beyond the buffer
				push_message(IdPiece, $urandom, $urandom_range(3));
			end else begin
				repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom_range(255)));
			end
		end
		// one buffer in five ends inside a message
		if (frame_q.size() > 1 && $urandom_range(4) == 0) begin
			max_cut = frame_q.size() - 1;
			if (max_cut > 6) max_cut = 6;
			repeat ($urandom_range(max_cut, 1)) void'(frame_q.pop_back());
		end
		send_buffer();
	endtask

	// result sink, random stall and watchdog
	initial begin : result_sink
		int  idle_run;
		bit  progress;
		idle_run = 0;
		while (idle_run < WatchdogLimit) begin
			@(posedge clk);
			progress = 1'b0;
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				sb.check_result(complete_bytes, status);
				progress = 1'b1;
			end
			if (byte_valid === 1'b1 && byte_stall === 1'b0) progress = 1'b1;
			idle_run = progress ? 0 : idle_run + 1;
			result_stall <= ($urandom_range(99) < stall_pct);
		end
		$display("simulation failed");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int phase_start;
		sb            = new();
		idle_pct      = 0;
		stall_pct     = 0;
		sent_bytes    = 0;
		arst_n        <= 1'b0;
		byte_valid    <= 1'b0;
		data_byte     <= '0;
		end_of_buffer <= 1'b0;
		result_stall  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single word: buffer ends inside the length prefix
		frame_q.push_back(8'hff);
		send_buffer();
		// keep-alive then a one-word message
		push_message('0, '0, 0);
		push_message(IdInterested, LenSimple, 0);
		send_buffer();
		// fixed-length messages with payload
		push_message(IdHave, LenHave, LenHave - 1);
		push_message(IdPort, LenPort, LenPort - 1);
		send_buffer();
		// known id with a wrong length, trailing words ignored after the stop
		push_message(IdInterested, LenSimple + 1, 2);
		send_buffer();
		// unknown id
		push_message(IdPort + 1, LenSimple, 0);
		send_buffer();
		// all-ones length cannot complete
		push_message(IdPiece, '1, 1);
		send_buffer();

		// random buffers under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct    = sender_idle[ph];
			stall_pct   = receiver_stall[ph];
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PhaseBytes) random_buffer();
		end
		byte_valid <= 1'b0;

		// drain outstanding results
		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
